@@ hdl/ftag_pkg.sv @@
// Shared constants, types and helper functions of the floor texel address generator.
`default_nettype none

package ftag_pkg;

    localparam int TEX_SIDE   = 64;
    localparam int TEX_BITS   = $clog2(TEX_SIDE);
    localparam int FRAC_BITS  = 8;
    localparam int QB         = FRAC_BITS + TEX_BITS;
    localparam int ROW_W      = 12;
    localparam int NUM_W      = 42;
    localparam int MAG_W      = NUM_W - 1;
    localparam int DIV_STEPS  = 3;
    localparam int DIV_STAGES = (MAG_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DVD_W      = DIV_STAGES * DIV_STEPS;
    localparam int FRONT_LAT  = 5;
    localparam int LATENCY    = FRONT_LAT + DIV_STAGES + 1;

    localparam logic [2:0] CFG_POS_X       = 3'd0;
    localparam logic [2:0] CFG_POS_Y       = 3'd1;
    localparam logic [2:0] CFG_EYE_HEIGHT  = 3'd2;
    localparam logic [2:0] CFG_FOCAL_DIST  = 3'd3;
    localparam logic [2:0] CFG_DIR_COS     = 3'd4;
    localparam logic [2:0] CFG_DIR_SIN     = 3'd5;
    localparam logic [2:0] CFG_HALF_WIDTH  = 3'd6;
    localparam logic [2:0] CFG_HALF_HEIGHT = 3'd7;

    localparam logic signed [15:0] DIR_MAX = 16'sd16384;
    localparam logic signed [15:0] DIR_MIN = -16'sd16384;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic [23:0]        height;
        logic [23:0]        focal;
        logic signed [15:0] dir_cos;
        logic signed [15:0] dir_sin;
        logic [11:0]        half_w;
        logic [11:0]        half_h;
    } cfg_t;

    typedef struct packed {
        logic                    vld;
        logic                    below;
        logic [ROW_W-1:0]        row;
        logic signed [NUM_W-1:0] num_x;
        logic signed [NUM_W-1:0] num_y;
    } div_in_t;

    typedef struct packed {
        logic          vld;
        logic          below;
        logic          sign_x;
        logic          sign_y;
        logic [QB-1:0] quo_x;
        logic [QB-1:0] quo_y;
    } div_out_t;

    typedef struct packed {
        logic [ROW_W-1:0]     rem;
        logic [DIV_STEPS-1:0] qbits;
    } div_step_t;

    function automatic logic signed [15:0] clamp_dir(input logic signed [15:0] d);
        logic signed [15:0] r;
        if (d > DIR_MAX)
            r = DIR_MAX;
        else if (d < DIR_MIN)
            r = DIR_MIN;
        else
            r = d;
        return r;
    endfunction

    // A few restoring division steps, dividend bits taken MSB first.
    function automatic div_step_t div_steps(input logic [ROW_W-1:0]     rem,
                                            input logic [DIV_STEPS-1:0] bits,
                                            input logic [ROW_W-1:0]     d);
        logic [ROW_W:0]       t;
        logic [ROW_W-1:0]     r;
        logic [DIV_STEPS-1:0] q;
        div_step_t            res;
        r = rem;
        q = '0;
        for (int k = DIV_STEPS - 1; k >= 0; k--)
        begin
            t = {r, bits[k]};
            if (t >= {1'b0, d})
            begin
                r    = ROW_W'(t - {1'b0, d});
                q[k] = 1'b1;
            end
            else
            begin
                r = t[ROW_W-1:0];
            end
        end
        res.rem   = r;
        res.qbits = q;
        return res;
    endfunction

endpackage

`default_nettype wire

@@ hdl/floor_texel_address_generator_core.sv @@
// Top level of the floor texel address generator: config port, pipeline and result register.
//
// One pixel per clock: busy stays low, so a pixel is taken at every edge with start high,
// and its result appears on the result ports, marked by done, for one cycle, in input
// order. Each pixel passes the 42-step restoring division by the screen row, three
// quotient bits per stage over 14 stages, behind a five-stage front end of offsets,
// direction products, inner sums, a split 41x24 multiply and its recombination.
// done cannot be held off. Configuration writes take effect at once and are meant for
// when no pixel is in flight. Pixels on or above the horizon return valid_res low and
// zero texel fields.
`default_nettype none

module floor_texel_address_generator_core
    import ftag_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output      logic        busy,
    input  wire logic [11:0] screen_x,
    input  wire logic [11:0] screen_y,
    output      logic        done,
    output      logic [5:0]  tex_u,
    output      logic [5:0]  tex_v,
    output      logic [11:0] texel_index,
    output      logic        valid_res,
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    cfg_t     cfg;
    div_in_t  front_out;
    div_out_t div_out;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    ftag_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ftag_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (start && !busy),
        .screen_x (screen_x),
        .screen_y (screen_y),
        .cfg      (cfg),
        .dout     (front_out)
    );

    ftag_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (front_out),
        .dout  (div_out)
    );

    // world = floor quotient + camera; texel = bits above the fraction
    logic [QB-1:0]         wx, wy;
    logic [TEX_BITS-1:0]   u, v;
    logic [2*TEX_BITS+11:0] idx_wide;

    logic        done_reg;
    logic        valid_reg, valid_next;
    logic [5:0]  u_reg, v_reg, u_next, v_next;
    logic [11:0] idx_reg, idx_next;

    always_comb
    begin
        wx = (div_out.quo_x ^ {QB{div_out.sign_x}}) + cfg.pos_x[QB-1:0];
        wy = (div_out.quo_y ^ {QB{div_out.sign_y}}) + cfg.pos_y[QB-1:0];
        u  = wx[QB-1:FRAC_BITS];
        v  = wy[QB-1:FRAC_BITS];
        idx_wide = {12'd0, v, u};
        valid_next = div_out.below;
        if (div_out.below)
        begin
            u_next   = 6'(u);
            v_next   = 6'(v);
            idx_next = idx_wide[11:0];
        end
        else
        begin
            u_next   = 6'd0;
            v_next   = 6'd0;
            idx_next = 12'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= div_out.vld;
    end

    always_ff @(posedge clk)
    begin
        valid_reg <= valid_next;
        u_reg     <= u_next;
        v_reg     <= v_next;
        idx_reg   <= idx_next;
    end

    assign done        = done_reg;
    assign valid_res   = valid_reg;
    assign tex_u       = u_reg;
    assign tex_v       = v_reg;
    assign texel_index = idx_reg;

endmodule

`default_nettype wire

@@ hdl/ftag_cfg.sv @@
// Configuration register bank with reset values and direction clamping.
`default_nettype none

module ftag_cfg
    import ftag_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire logic [2:0]  wr_index,
    input  wire logic [23:0] wr_data,
    output cfg_t             cfg
);

    logic [23:0] pos_x_reg, pos_y_reg, height_reg, focal_reg;
    logic [15:0] cos_reg, sin_reg;
    logic [11:0] hw_reg, hh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg  <= 24'd0;
            pos_y_reg  <= 24'd0;
            height_reg <= 24'd12288;
            focal_reg  <= 24'd102400;
            cos_reg    <= 16'd16384;
            sin_reg    <= 16'd0;
            hw_reg     <= 12'd320;
            hh_reg     <= 12'd240;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_POS_X:       pos_x_reg  <= wr_data;
                CFG_POS_Y:       pos_y_reg  <= wr_data;
                CFG_EYE_HEIGHT:  height_reg <= wr_data;
                CFG_FOCAL_DIST:  focal_reg  <= wr_data;
                CFG_DIR_COS:     cos_reg    <= wr_data[15:0];
                CFG_DIR_SIN:     sin_reg    <= wr_data[15:0];
                CFG_HALF_WIDTH:  hw_reg     <= wr_data[11:0];
                CFG_HALF_HEIGHT: hh_reg     <= wr_data[11:0];
            endcase
        end
    end

    always_comb
    begin
        cfg.pos_x   = $signed(pos_x_reg);
        cfg.pos_y   = $signed(pos_y_reg);
        cfg.height  = height_reg;
        cfg.focal   = focal_reg;
        cfg.dir_cos = clamp_dir($signed(cos_reg));
        cfg.dir_sin = clamp_dir($signed(sin_reg));
        cfg.half_w  = hw_reg;
        cfg.half_h  = hh_reg;
    end

endmodule

`default_nettype wire

@@ hdl/ftag_front.sv @@
// Front pipeline: screen offsets, direction products, inner sums, height products, scaled numerators.
`default_nettype none

module ftag_front
    import ftag_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_vld,
    input  wire logic [11:0] screen_x,
    input  wire logic [11:0] screen_y,
    input  wire cfg_t        cfg,
    output div_in_t          dout
);

    // stage 0: row and column offsets
    logic              s0_vld_reg;
    logic              s0_below_reg, s0_below_next;
    logic [ROW_W-1:0]  s0_row_reg;
    logic signed [12:0] s0_col_reg, s0_col_next;
    logic [12:0]       row_full;

    always_comb
    begin
        row_full      = {1'b0, screen_y} - {1'b0, cfg.half_h};
        s0_below_next = !row_full[12] && (row_full != 13'd0);
        s0_col_next   = $signed({1'b0, screen_x} - {1'b0, cfg.half_w});
    end

    // stage 1: direction products
    logic              s1_vld_reg, s1_below_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic signed [40:0] fc_reg, fs_reg, fc_next, fs_next;
    logic signed [28:0] cs_reg, cc_reg, cs_next, cc_next;

    always_comb
    begin
        fc_next = $signed({1'b0, cfg.focal}) * cfg.dir_cos;
        fs_next = $signed({1'b0, cfg.focal}) * cfg.dir_sin;
        cs_next = s0_col_reg * cfg.dir_sin;
        cc_next = s0_col_reg * cfg.dir_cos;
    end

    // stage 2: inner sums, units of 2^-22
    logic              s2_vld_reg, s2_below_reg;
    logic [ROW_W-1:0]  s2_row_reg;
    logic signed [40:0] ax_reg, ay_reg, ax_next, ay_next;

    always_comb
    begin
        ax_next = fc_reg + $signed({{4{cs_reg[28]}}, cs_reg, 8'd0});
        ay_next = fs_reg - $signed({{4{cc_reg[28]}}, cc_reg, 8'd0});
    end

    // stage 3: split multiply by eye height
    logic              s3_vld_reg, s3_below_reg;
    logic [ROW_W-1:0]  s3_row_reg;
    logic [44:0]        lo_x_reg, lo_y_reg, lo_x_next, lo_y_next;
    logic signed [44:0] hi_x_reg, hi_y_reg, hi_x_next, hi_y_next;

    always_comb
    begin
        lo_x_next = ax_reg[20:0] * cfg.height;
        lo_y_next = ay_reg[20:0] * cfg.height;
        hi_x_next = $signed(ax_reg[40:21]) * $signed({1'b0, cfg.height});
        hi_y_next = $signed(ay_reg[40:21]) * $signed({1'b0, cfg.height});
    end

    // stage 4: recombine and floor by 2^22
    logic              s4_vld_reg, s4_below_reg;
    logic [ROW_W-1:0]  s4_row_reg;
    logic signed [NUM_W-1:0] num_x_reg, num_y_reg, num_x_next, num_y_next;
    logic signed [65:0] px, py;

    always_comb
    begin
        px = (66'(hi_x_reg) <<< 21) + $signed(66'(lo_x_reg));
        py = (66'(hi_y_reg) <<< 21) + $signed(66'(lo_y_reg));
        num_x_next = px[63:22];
        num_y_next = py[63:22];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else
        begin
            s0_vld_reg <= in_vld;
            s1_vld_reg <= s0_vld_reg;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_below_reg <= s0_below_next;
        s0_row_reg   <= row_full[ROW_W-1:0];
        s0_col_reg   <= s0_col_next;

        s1_below_reg <= s0_below_reg;
        s1_row_reg   <= s0_row_reg;
        fc_reg       <= fc_next;
        fs_reg       <= fs_next;
        cs_reg       <= cs_next;
        cc_reg       <= cc_next;

        s2_below_reg <= s1_below_reg;
        s2_row_reg   <= s1_row_reg;
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;

        s3_below_reg <= s2_below_reg;
        s3_row_reg   <= s2_row_reg;
        lo_x_reg     <= lo_x_next;
        lo_y_reg     <= lo_y_next;
        hi_x_reg     <= hi_x_next;
        hi_y_reg     <= hi_y_next;

        s4_below_reg <= s3_below_reg;
        s4_row_reg   <= s3_row_reg;
        num_x_reg    <= num_x_next;
        num_y_reg    <= num_y_next;
    end

    always_comb
    begin
        dout.vld   = s4_vld_reg;
        dout.below = s4_below_reg;
        dout.row   = s4_row_reg;
        dout.num_x = num_x_reg;
        dout.num_y = num_y_reg;
    end

endmodule

`default_nettype wire

@@ hdl/ftag_div.sv @@
// Pipelined restoring floor divider by the screen row, both world axes side by side.
`default_nettype none

module ftag_div
    import ftag_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire div_in_t din,
    output div_out_t     dout
);

    // floor(n / r) = n >= 0 ? n / r : ~(~n / r)
    logic [MAG_W-1:0] mag_x, mag_y;

    always_comb
    begin
        mag_x = din.num_x[MAG_W-1:0] ^ {MAG_W{din.num_x[NUM_W-1]}};
        mag_y = din.num_y[MAG_W-1:0] ^ {MAG_W{din.num_y[NUM_W-1]}};
    end

    logic             vld_reg    [DIV_STAGES];
    logic             below_reg  [DIV_STAGES];
    logic             sign_x_reg [DIV_STAGES];
    logic             sign_y_reg [DIV_STAGES];
    logic [ROW_W-1:0] row_reg    [DIV_STAGES];
    logic [ROW_W-1:0] rem_x_reg  [DIV_STAGES];
    logic [ROW_W-1:0] rem_y_reg  [DIV_STAGES];
    logic [DVD_W-1:0] dvd_x_reg  [DIV_STAGES];
    logic [DVD_W-1:0] dvd_y_reg  [DIV_STAGES];
    logic [QB-1:0]    quo_x_reg  [DIV_STAGES];
    logic [QB-1:0]    quo_y_reg  [DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_stage
        logic             vld_in, below_in, sign_x_in, sign_y_in;
        logic [ROW_W-1:0] row_in, rem_x_in, rem_y_in;
        logic [DVD_W-1:0] dvd_x_in, dvd_y_in;
        logic [QB-1:0]    quo_x_in, quo_y_in;
        div_step_t        step_x, step_y;

        if (g == 0)
        begin : g_first
            assign vld_in    = din.vld;
            assign below_in  = din.below;
            assign sign_x_in = din.num_x[NUM_W-1];
            assign sign_y_in = din.num_y[NUM_W-1];
            assign row_in    = din.row;
            assign rem_x_in  = '0;
            assign rem_y_in  = '0;
            assign dvd_x_in  = DVD_W'(mag_x);
            assign dvd_y_in  = DVD_W'(mag_y);
            assign quo_x_in  = '0;
            assign quo_y_in  = '0;
        end
        else
        begin : g_next
            assign vld_in    = vld_reg[g-1];
            assign below_in  = below_reg[g-1];
            assign sign_x_in = sign_x_reg[g-1];
            assign sign_y_in = sign_y_reg[g-1];
            assign row_in    = row_reg[g-1];
            assign rem_x_in  = rem_x_reg[g-1];
            assign rem_y_in  = rem_y_reg[g-1];
            assign dvd_x_in  = dvd_x_reg[g-1];
            assign dvd_y_in  = dvd_y_reg[g-1];
            assign quo_x_in  = quo_x_reg[g-1];
            assign quo_y_in  = quo_y_reg[g-1];
        end

        always_comb
        begin
            step_x = div_steps(rem_x_in, dvd_x_in[DVD_W-1 -: DIV_STEPS], row_in);
            step_y = div_steps(rem_y_in, dvd_y_in[DVD_W-1 -: DIV_STEPS], row_in);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g] <= 1'b0;
            else
                vld_reg[g] <= vld_in;
        end

        // only the low quotient bits reach the texel
        always_ff @(posedge clk)
        begin
            below_reg[g]  <= below_in;
            sign_x_reg[g] <= sign_x_in;
            sign_y_reg[g] <= sign_y_in;
            row_reg[g]    <= row_in;
            rem_x_reg[g]  <= step_x.rem;
            rem_y_reg[g]  <= step_y.rem;
            dvd_x_reg[g]  <= dvd_x_in << DIV_STEPS;
            dvd_y_reg[g]  <= dvd_y_in << DIV_STEPS;
            quo_x_reg[g]  <= QB'({quo_x_in, step_x.qbits});
            quo_y_reg[g]  <= QB'({quo_y_in, step_y.qbits});
        end
    end

    always_comb
    begin
        dout.vld    = vld_reg[DIV_STAGES-1];
        dout.below  = below_reg[DIV_STAGES-1];
        dout.sign_x = sign_x_reg[DIV_STAGES-1];
        dout.sign_y = sign_y_reg[DIV_STAGES-1];
        dout.quo_x  = quo_x_reg[DIV_STAGES-1];
        dout.quo_y  = quo_y_reg[DIV_STAGES-1];
    end

endmodule

`default_nettype wire

@@ hdl/ftag_chk.sv @@
// Port-level checker for the floor texel address generator, bound to the top level.
`default_nettype none

module ftag_chk
    import ftag_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [11:0] screen_x,
    input wire logic [11:0] screen_y,
    input wire logic        done,
    input wire logic [5:0]  tex_u,
    input wire logic [5:0]  tex_v,
    input wire logic [11:0] texel_index,
    input wire logic        valid_res,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic [2:0]  cfg_index,
    input wire logic [23:0] cfg_data
);

    // every accepted transaction returns a result strobe
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result strobe missing after accepted transaction");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result strobe without a matching transaction");

    a_above_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !valid_res) |-> (tex_u == 6'd0 && tex_v == 6'd0 && texel_index == 12'd0))
        else $error("non-zero texel for a pixel above the horizon");

    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        (done && valid_res) |-> (texel_index == {tex_v, tex_u}))
        else $error("texel index does not match row and column");

endmodule

bind floor_texel_address_generator_core ftag_chk u_ftag_chk (.*);

`default_nettype wire
